### hw/rtl/pms_pkg.sv
package pms_pkg;

    // Text unit and configuration word geometry
    localparam int UNIT_BITS      = 16;
    localparam int LEN_BITS       = 4;
    localparam int CFG_WORD_BITS  = 64;
    localparam int CFG_INDEX_BITS = 3;
    localparam int PATTERN_UNITS  = 12;
    localparam int UNITS_PER_REG  = 4;
    localparam int SINCE_BITS     = 4;

    localparam logic [UNIT_BITS-1:0]  SPACE_UNIT = 16'h0020;
    localparam logic [SINCE_BITS-1:0] SINCE_MAX  = 4'hF;

    // Configuration register indexes
    typedef enum logic [CFG_INDEX_BITS-1:0] {
        REG_PATTERN_LENGTH = 3'd0,
        REG_UNITS_LOW      = 3'd1,
        REG_UNITS_MID      = 3'd2,
        REG_UNITS_HIGH     = 3'd3
    } cfg_reg_t;

    // Input beat
    typedef struct packed {
        logic [UNIT_BITS-1:0] text_unit;
        logic                 end_of_text;
    } in_beat_t;

    // Output beat
    typedef struct packed {
        logic [UNIT_BITS-1:0] out_unit;
        logic                 out_last;
    } out_beat_t;

endpackage

### hw/rtl/pattern_mask_stream.sv
// Channel   Dir  Handshake            Payload
// s_        in   s_valid / s_ready    pms_pkg::in_beat_t  (text_unit, end_of_text)
// m_        out  m_valid / m_ready    pms_pkg::out_beat_t (out_unit, out_last)
// cfg_      in   cfg_valid / cfg_ready cfg_index, cfg_data (always ready)
//
// One text unit per cycle in steady state while m_ready is high; a unit leaves L-1 beats after it
// arrived, from the oldest cell of a newest-first shift chain of MAX_PATTERN cells.
// A beat that releases k units (end of text, or a shorter length) sends the first
// unit out with the beat; the rest drain one per cycle from the oldest cell while
// s_ready is low and the output is free. The single output register sets the stall
// coupling: s_ready needs m_valid low or m_ready high.
// Reset is synchronous and needs no clearing pass.
module pattern_mask_stream #(
    parameter int MAX_PATTERN = 12
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  pms_pkg::in_beat_t                   s_data,
    output logic                                m_valid,
    input  logic                                m_ready,
    output pms_pkg::out_beat_t                  m_data,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [pms_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
    input  logic [pms_pkg::CFG_WORD_BITS-1:0]   cfg_data
);
    import pms_pkg::*;

    localparam int CW = $clog2(MAX_PATTERN + 1);
    localparam int IW = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;
    localparam int NW = (CW > LEN_BITS) ? CW : LEN_BITS;

    logic [LEN_BITS-1:0]   len_eff;
    logic [UNIT_BITS-1:0]  exp_new;
    logic [UNIT_BITS-1:0]  exp_cell  [MAX_PATTERN];
    logic [UNIT_BITS-1:0]  cell_unit [MAX_PATTERN];
    logic                  cell_mask [MAX_PATTERN];
    logic                  cell_eq   [MAX_PATTERN];
    logic [UNIT_BITS-1:0]  post_unit [MAX_PATTERN];
    logic                  post_mask [MAX_PATTERN];

    logic [CW-1:0]         cnt_reg, cnt_next;
    logic [CW-1:0]         pend_reg, pend_next;
    logic                  drain_last_reg, drain_last_next;
    logic [SINCE_BITS-1:0] since_reg, since_next;
    logic                  m_valid_reg, m_valid_next;
    out_beat_t             m_data_reg, m_data_next;

    logic                  out_free, accept, drain, load_out, hit, cells_ok, eot;
    logic [NW-1:0]         len_n, keep_n, total_n, emit_n;
    logic [SINCE_BITS-1:0] since_inc;
    logic [CW-1:0]         cnt_dec;
    logic [IW-1:0]         acc_idx, drn_idx;
    logic [UNIT_BITS-1:0]  sel_unit;
    logic                  sel_mask;

    pms_cfg #(
        .MAX_PATTERN (MAX_PATTERN)
    ) u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .len_eff   (len_eff),
        .exp_new   (exp_new),
        .exp_cell  (exp_cell)
    );

    // Handshake
    assign out_free = !m_valid_reg || m_ready;
    assign s_ready  = (pend_reg == '0) && out_free;
    assign accept   = s_valid && s_ready;
    assign drain    = (pend_reg != '0) && out_free;
    assign eot      = s_data.end_of_text;

    // Window arithmetic
    assign len_n     = NW'(len_eff);
    assign keep_n    = (len_n == '0) ? '0 : len_n - NW'(1);
    assign total_n   = NW'(cnt_reg) + NW'(1);
    assign since_inc = (since_reg == SINCE_MAX) ? since_reg : since_reg + SINCE_BITS'(1);
    assign emit_n    = eot ? total_n :
                       ((total_n > keep_n) ? total_n - keep_n : '0);

    // Match test over the incoming unit and the held cells in range
    always_comb begin
        cells_ok = 1'b1;
        for (int j = 0; j < MAX_PATTERN; j++) begin
            if ((NW'(j + 1) < len_n) && !cell_eq[j]) cells_ok = 1'b0;
        end
    end

    assign hit = (len_n != '0) && (total_n >= len_n) && (NW'(since_inc) >= len_n)
                 && (s_data.text_unit == exp_new) && cells_ok;

    // Shift values: incoming unit enters cell 0, a hit marks the newest len cells
    assign post_unit[0] = s_data.text_unit;
    assign post_mask[0] = hit && (len_n != '0);
    for (genvar j = 1; j < MAX_PATTERN; j++) begin : g_post
        assign post_unit[j] = cell_unit[j-1];
        assign post_mask[j] = cell_mask[j-1] || (hit && (NW'(j) < len_n));
    end

    // Cell chain
    for (genvar j = 0; j < MAX_PATTERN; j++) begin : g_cell
        pms_cell u_cell (
            .aclk        (aclk),
            .aresetn     (aresetn),
            .shift_en    (accept),
            .load_unit   (post_unit[j]),
            .load_mask   (post_mask[j]),
            .expect_unit (exp_cell[j]),
            .unit        (cell_unit[j]),
            .mask        (cell_mask[j]),
            .equal       (cell_eq[j])
        );
    end

    // Pick the oldest unit: from the shifted view on a beat, from the cells in drain
    assign cnt_dec = cnt_reg - CW'(1);
    assign acc_idx = cnt_reg[IW-1:0];
    assign drn_idx = cnt_dec[IW-1:0];
    assign sel_unit = accept ? post_unit[acc_idx] : cell_unit[drn_idx];
    assign sel_mask = accept ? post_mask[acc_idx] : cell_mask[drn_idx];

    // Next state
    always_comb begin
        cnt_next        = cnt_reg;
        pend_next       = pend_reg;
        drain_last_next = drain_last_reg;
        since_next      = since_reg;
        load_out        = 1'b0;
        m_data_next     = m_data_reg;
        if (accept) begin
            cnt_next        = (emit_n != '0) ? CW'(total_n - NW'(1)) : CW'(total_n);
            pend_next       = (emit_n != '0) ? CW'(emit_n - NW'(1)) : '0;
            drain_last_next = eot;
            since_next      = eot ? SINCE_MAX : (hit ? '0 : since_inc);
            load_out        = (emit_n != '0);
            m_data_next.out_last = eot && (emit_n == NW'(1));
        end else if (drain) begin
            cnt_next  = cnt_dec;
            pend_next = pend_reg - CW'(1);
            load_out  = 1'b1;
            m_data_next.out_last = drain_last_reg && (pend_reg == CW'(1));
        end
        if (load_out) begin
            m_data_next.out_unit = sel_mask ? SPACE_UNIT : sel_unit;
        end
        if (load_out) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg        <= '0;
            pend_reg       <= '0;
            drain_last_reg <= 1'b0;
            since_reg      <= SINCE_MAX;
            m_valid_reg    <= 1'b0;
        end else begin
            cnt_reg        <= cnt_next;
            pend_reg       <= pend_next;
            drain_last_reg <= drain_last_next;
            since_reg      <= since_next;
            m_valid_reg    <= m_valid_next;
        end
    end

    // Output payload
    always_ff @(posedge aclk) begin
        if (load_out) m_data_reg <= m_data_next;
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    // Held count never passes the chain length
    a_cnt_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        int'(cnt_reg) <= MAX_PATTERN)
        else $error("held count beyond cell chain");

    // Outside a drain at least one cell short of full
    a_idle_room: assert property (@(posedge aclk) disable iff (!aresetn)
        (pend_reg == '0) |-> (int'(cnt_reg) < MAX_PATTERN))
        else $error("no room for the next unit");

    // A drain never asks for more units than are held
    a_pend_le_cnt: assert property (@(posedge aclk) disable iff (!aresetn)
        pend_reg <= cnt_reg)
        else $error("drain runs past held units");

    // The last unit of a text leaves an empty, fresh window
    a_last_flush: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_data.out_last) |->
            ((cnt_reg == '0) && (pend_reg == '0) && (since_reg == SINCE_MAX)))
        else $error("window not flushed at end of text");

endmodule

### hw/rtl/pms_cfg.sv
module pms_cfg #(
    parameter int MAX_PATTERN = 12
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [pms_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
    input  logic [pms_pkg::CFG_WORD_BITS-1:0]   cfg_data,
    output logic [pms_pkg::LEN_BITS-1:0]        len_eff,
    output logic [pms_pkg::UNIT_BITS-1:0]       exp_new,
    output logic [pms_pkg::UNIT_BITS-1:0]       exp_cell [MAX_PATTERN]
);
    import pms_pkg::*;

    logic [LEN_BITS-1:0]      len_reg;
    logic [CFG_WORD_BITS-1:0] pat_reg [3];
    logic [UNIT_BITS-1:0]     pat_unit [MAX_PATTERN];

    assign cfg_ready = 1'b1;

    // Take register writes; unknown indexes are dropped
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            len_reg    <= '0;
            pat_reg[0] <= '0;
            pat_reg[1] <= '0;
            pat_reg[2] <= '0;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_reg_t'(cfg_index))
                REG_PATTERN_LENGTH: len_reg    <= cfg_data[LEN_BITS-1:0];
                REG_UNITS_LOW:      pat_reg[0] <= cfg_data;
                REG_UNITS_MID:      pat_reg[1] <= cfg_data;
                REG_UNITS_HIGH:     pat_reg[2] <= cfg_data;
                default: ;
            endcase
        end
    end

    // Clamp an oversized length to the window size
    assign len_eff = (int'(len_reg) > MAX_PATTERN) ? LEN_BITS'(MAX_PATTERN) : len_reg;

    // Unpack pattern units; units past the register file read as zero
    for (genvar k = 0; k < MAX_PATTERN; k++) begin : g_unit
        if (k < PATTERN_UNITS) begin : g_reg
            assign pat_unit[k] =
                pat_reg[k / UNITS_PER_REG][UNIT_BITS * (k % UNITS_PER_REG) +: UNIT_BITS];
        end else begin : g_zero
            assign pat_unit[k] = '0;
        end
    end

    // Align the pattern to the newest-first window: the incoming unit meets
    // the last pattern unit, cell j meets unit len-2-j
    always_comb begin
        exp_new = '0;
        for (int k = 0; k < MAX_PATTERN; k++) begin
            if (k + 1 == int'(len_eff)) exp_new = pat_unit[k];
        end
        for (int j = 0; j < MAX_PATTERN; j++) begin
            exp_cell[j] = '0;
            for (int k = 0; k < MAX_PATTERN; k++) begin
                if (k + j + 2 == int'(len_eff)) exp_cell[j] = pat_unit[k];
            end
        end
    end

endmodule

### hw/rtl/pms_cell.sv
module pms_cell (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           shift_en,
    input  logic [pms_pkg::UNIT_BITS-1:0]  load_unit,
    input  logic                           load_mask,
    input  logic [pms_pkg::UNIT_BITS-1:0]  expect_unit,
    output logic [pms_pkg::UNIT_BITS-1:0]  unit,
    output logic                           mask,
    output logic                           equal
);
    import pms_pkg::*;

    logic [UNIT_BITS-1:0] unit_reg;
    logic                 mask_reg;

    // Advance one place along the window on every accepted beat
    always_ff @(posedge aclk) begin
        if (shift_en) unit_reg <= load_unit;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mask_reg <= 1'b0;
        end else if (shift_en) begin
            mask_reg <= load_mask;
        end
    end

    // Compare the held unit against its pattern slot
    assign equal = (unit_reg == expect_unit);
    assign unit  = unit_reg;
    assign mask  = mask_reg;

endmodule
